// ===== design/godpg_pkg.sv =====
// Package for the Gray-order diagonal phase gate block: op codes, register
// indexes, the control state encoding and fixed constants. No dependencies.
`default_nettype none
package godpg_pkg;
    typedef enum logic [1:0] {
        OP_LOAD_CZ = 2'd0,
        OP_LOAD_T  = 2'd1,
        OP_AMP     = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CZ, ST_PHASE, ST_MUL, ST_SCALE, ST_NEG,
        ST_ROT, ST_ROUND, ST_OUT
    } state_t;

    localparam logic [1:0] REG_QUBITS = 2'd0;
    localparam logic [1:0] REG_PHASES = 2'd1;
    localparam logic [1:0] REG_SCALE_RE = 2'd2;
    localparam logic [1:0] REG_SCALE_IM = 2'd3;

    localparam int CFG_WIDTH = 18;
    localparam int INDEX_WIDTH = 20;
    localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;
endpackage
`default_nettype wire

// ===== design/godpg_ram.sv =====
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module godpg_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 20
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== design/gray_order_diagonal_phase_gates.sv =====
// Top level of the Gray-order diagonal phase gate block.
// Depends on godpg_pkg and godpg_ram.
`default_nettype none
// The block takes one beat at a time. A mask load, or an ignored op, leaves
// the block idle, and the next beat can be accepted at the following edge.
// An amplitude beat first reads the controlled-Z mask of the changed qubit,
// then reads the np T masks from the phase memory one per cycle to build
// the phase step k (np being the phase mask count in use, at most
// MAX_PHASE_MASKS), then passes through the registered states for the
// rescale product, its rounding, the sign, the rotation and the rotation
// rounding, and the output state loading the output register. No new beat
// is taken until the amplitude beat has left the output state. If the
// output register still holds an unread result, the block waits in its
// output state until that result is taken. The result waits in the output
// register, and the next beat is accepted while it waits. Both mask
// memories are cleared after reset by a sweep over max(MAX_QUBITS,
// MAX_PHASE_MASKS) addresses, during which no beat is taken; configuration
// writes are taken at any time.
module gray_order_diagonal_phase_gates #(
    parameter int MAX_QUBITS      = 20,
    parameter int MAX_PHASE_MASKS = 8,
    parameter int AMP_BITS        = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [17:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           op,
    input  wire logic [4:0]           table_slot,
    input  wire logic [19:0]          mask_word,
    input  wire logic signed [AMP_BITS-1:0] in_real,
    input  wire logic signed [AMP_BITS-1:0] in_imag,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [19:0]               state_index,
    output logic signed [AMP_BITS-1:0] out_real,
    output logic signed [AMP_BITS-1:0] out_imag,
    output logic                      final_amp
);
    localparam int QA = (MAX_QUBITS > 1) ? $clog2(MAX_QUBITS) : 1;
    localparam int PA = (MAX_PHASE_MASKS > 1) ? $clog2(MAX_PHASE_MASKS) : 1;
    localparam int SWEEP = (MAX_QUBITS > MAX_PHASE_MASKS) ? MAX_QUBITS : MAX_PHASE_MASKS;
    localparam int SW = $clog2(SWEEP + 1);
    localparam int PC = $clog2(MAX_PHASE_MASKS + 1);
    localparam int PRODW = AMP_BITS + 19;
    localparam logic signed [PRODW+1:0] AMP_MAX = (PRODW+2)'((64'sd1 <<< (AMP_BITS-1)) - 1);
    localparam logic signed [PRODW+1:0] AMP_MIN = -AMP_MAX - 1;

    godpg_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [4:0] qubits_reg;
    logic [3:0] phases_reg;
    logic signed [17:0] scale_re_reg, scale_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qubits_reg   <= 5'd20;
            phases_reg   <= '0;
            scale_re_reg <= '0;
            scale_im_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                godpg_pkg::REG_QUBITS:   qubits_reg   <= cfg_data[4:0];
                godpg_pkg::REG_PHASES:   phases_reg   <= cfg_data[3:0];
                godpg_pkg::REG_SCALE_RE: scale_re_reg <= cfg_data;
                godpg_pkg::REG_SCALE_IM: scale_im_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective qubit count and phase mask count.
    logic [5:0] n_eff;
    logic [PC-1:0] np_eff;
    logic [19:0] vec_mask;
    always_comb
    begin
        if (qubits_reg == 5'd0)
            n_eff = 6'd1;
        else if (32'(qubits_reg) > MAX_QUBITS)
            n_eff = 6'(MAX_QUBITS);
        else
            n_eff = {1'b0, qubits_reg};
        if (32'(phases_reg) > MAX_PHASE_MASKS)
            np_eff = PC'(MAX_PHASE_MASKS);
        else
            np_eff = PC'(phases_reg);
        vec_mask = 20'((64'd1 << n_eff) - 64'd1);
    end

    logic accept_in;
    assign in_stall  = (state_reg != godpg_pkg::ST_IDLE);
    assign accept_in = in_valid && !in_stall;

    // Clear sweep counter, phase read counter.
    logic [SW-1:0] sweep_reg;
    logic [PC-1:0] pidx_reg;

    // Stream state.
    logic [19:0] count_reg, prev_reg;
    logic        sign_reg;

    // Beat registers.
    logic [19:0] gc_reg;
    logic        changed_reg, last_reg;
    logic signed [AMP_BITS-1:0] a_reg, b_reg;
    logic [2:0]  k_reg;
    logic        rd_valid_reg;

    // Gray index and changed qubit for an arriving amplitude.
    logic [19:0] cnt_in, gc_in, changed_in;
    logic [4:0]  p_in;
    always_comb
    begin
        cnt_in     = count_reg & vec_mask;
        gc_in      = cnt_in ^ (cnt_in >> 1);
        changed_in = gc_in ^ (prev_reg & vec_mask);
        p_in       = '0;
        for (int i = 19; i >= 0; i--)
        begin
            if (changed_in[i])
                p_in = 5'(i);
        end
    end

    // Memories.
    logic          cz_we, ph_we;
    logic [QA-1:0] cz_waddr, cz_raddr;
    logic [PA-1:0] ph_waddr, ph_raddr;
    logic [19:0]   cz_wdata, ph_wdata, cz_rdata, ph_rdata;
    logic          clearing;

    assign clearing = (state_reg == godpg_pkg::ST_CLEAR);
    always_comb
    begin
        cz_we    = 1'b0;
        ph_we    = 1'b0;
        cz_waddr = QA'(table_slot);
        ph_waddr = PA'(table_slot);
        cz_wdata = mask_word;
        ph_wdata = mask_word;
        if (clearing)
        begin
            cz_we    = (32'(sweep_reg) < MAX_QUBITS);
            ph_we    = (32'(sweep_reg) < MAX_PHASE_MASKS);
            cz_waddr = QA'(sweep_reg);
            ph_waddr = PA'(sweep_reg);
            cz_wdata = '0;
            ph_wdata = '0;
        end
        else if (accept_in)
        begin
            cz_we = (op == godpg_pkg::OP_LOAD_CZ) && (32'(table_slot) < MAX_QUBITS);
            ph_we = (op == godpg_pkg::OP_LOAD_T) && (32'(table_slot) < MAX_PHASE_MASKS);
        end
        cz_raddr = QA'(6'(n_eff - 6'd1 - {1'b0, p_in}));
        ph_raddr = PA'(pidx_reg);
    end

    godpg_ram #(.WIDTH(20), .DEPTH(MAX_QUBITS)) u_cz_ram (
        .clk(clk), .wr_en(cz_we), .wr_addr(cz_waddr), .wr_data(cz_wdata),
        .rd_addr(cz_raddr), .rd_data(cz_rdata)
    );
    godpg_ram #(.WIDTH(20), .DEPTH(MAX_PHASE_MASKS)) u_ph_ram (
        .clk(clk), .wr_en(ph_we), .wr_addr(ph_waddr), .wr_data(ph_wdata),
        .rd_addr(ph_raddr), .rd_data(ph_rdata)
    );

    // Output register is free when empty or being taken.
    logic out_free;
    assign out_free = !out_valid || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            godpg_pkg::ST_CLEAR:
                if (32'(sweep_reg) == SWEEP - 1) state_next = godpg_pkg::ST_IDLE;
            godpg_pkg::ST_IDLE:
                if (accept_in && op == godpg_pkg::OP_AMP) state_next = godpg_pkg::ST_CZ;
            godpg_pkg::ST_CZ:
                state_next = (np_eff == '0) ? godpg_pkg::ST_MUL : godpg_pkg::ST_PHASE;
            godpg_pkg::ST_PHASE:
                if (pidx_reg == np_eff) state_next = godpg_pkg::ST_MUL;
            godpg_pkg::ST_MUL:   state_next = godpg_pkg::ST_SCALE;
            godpg_pkg::ST_SCALE: state_next = godpg_pkg::ST_NEG;
            godpg_pkg::ST_NEG:   state_next = godpg_pkg::ST_ROT;
            godpg_pkg::ST_ROT:   state_next = godpg_pkg::ST_ROUND;
            godpg_pkg::ST_ROUND: state_next = godpg_pkg::ST_OUT;
            godpg_pkg::ST_OUT:   if (out_free) state_next = godpg_pkg::ST_IDLE;
            default:             state_next = godpg_pkg::ST_IDLE;
        endcase
    end

    // Datapath.
    logic signed [PRODW:0] mre_reg, mim_reg, mre2_reg, mim2_reg;
    logic signed [PRODW+1:0] rot_a_reg, rot_b_reg;
    logic signed [PRODW+1:0] t_re, t_im;
    logic scaling;
    assign scaling = (scale_re_reg != '0) || (scale_im_reg != '0);

    function automatic logic signed [AMP_BITS-1:0] sat_f(input logic signed [PRODW+1:0] x);
        if (x > AMP_MAX)
            sat_f = AMP_BITS'(AMP_MAX);
        else if (x < AMP_MIN)
            sat_f = AMP_BITS'(AMP_MIN);
        else
            sat_f = AMP_BITS'(x);
    endfunction

    always_comb
    begin
        t_re = (PRODW+2)'(mre_reg) + (PRODW+2)'(mre2_reg) + (PRODW+2)'(8192);
        t_im = (PRODW+2)'(mim_reg) + (PRODW+2)'(mim2_reg) + (PRODW+2)'(8192);
    end

    // Rotation operands after the sign stage.
    logic signed [PRODW+1:0] sa, sb, ssum, sdif;
    always_comb
    begin
        sa   = (PRODW+2)'(a_reg);
        sb   = (PRODW+2)'(b_reg);
        ssum = sa + sb;
        sdif = sa - sb;
    end

    // The odd phase steps scale a signed sum or difference by 1/sqrt2. The
    // sign is applied before the rounding, so the operands for the real and
    // the imaginary part are chosen, already negated where needed, in the
    // rotation stage.
    logic signed [PRODW+1:0] rot_a, rot_b;
    always_comb
    begin
        rot_a = (rot_a_reg * $signed({1'b0, godpg_pkg::INV_SQRT2_Q16}) + 32768) >>> 16;
        rot_b = (rot_b_reg * $signed({1'b0, godpg_pkg::INV_SQRT2_Q16}) + 32768) >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= godpg_pkg::ST_CLEAR;
            sweep_reg    <= '0;
            pidx_reg     <= '0;
            count_reg    <= '0;
            prev_reg     <= '0;
            sign_reg     <= 1'b0;
            out_valid    <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                sweep_reg <= sweep_reg + SW'(1);
            if (state_reg == godpg_pkg::ST_OUT && out_free)
                out_valid <= 1'b1;
            else if (out_valid && !out_stall)
                out_valid <= 1'b0;
            unique case (state_reg)
                godpg_pkg::ST_IDLE:
                begin
                    pidx_reg <= '0;
                    rd_valid_reg <= 1'b0;
                    if (accept_in && op == godpg_pkg::OP_AMP)
                    begin
                        gc_reg      <= gc_in;
                        changed_reg <= (changed_in != '0);
                        last_reg    <= (cnt_in == vec_mask);
                        a_reg       <= in_real;
                        b_reg       <= in_imag;
                        k_reg       <= '0;
                    end
                end
                godpg_pkg::ST_CZ:
                begin
                    if (changed_reg && ^(cz_rdata & gc_reg))
                        sign_reg <= !sign_reg;
                    pidx_reg <= pidx_reg + PC'(1);
                    rd_valid_reg <= 1'b1;
                end
                godpg_pkg::ST_PHASE:
                begin
                    if (rd_valid_reg)
                        k_reg <= k_reg + 3'($countones(ph_rdata & gc_reg));
                    if (pidx_reg != np_eff)
                        pidx_reg <= pidx_reg + PC'(1);
                end
                godpg_pkg::ST_MUL:
                begin
                    mre_reg  <= (PRODW+1)'(a_reg * scale_re_reg);
                    mre2_reg <= (PRODW+1)'(-(b_reg * scale_im_reg));
                    mim_reg  <= (PRODW+1)'(a_reg * scale_im_reg);
                    mim2_reg <= (PRODW+1)'(b_reg * scale_re_reg);
                end
                godpg_pkg::ST_SCALE:
                begin
                    if (scaling)
                    begin
                        a_reg <= sat_f(t_re >>> 14);
                        b_reg <= sat_f(t_im >>> 14);
                    end
                end
                godpg_pkg::ST_NEG:
                begin
                    if (sign_reg)
                    begin
                        a_reg <= sat_f(-sa);
                        b_reg <= sat_f(-sb);
                    end
                end
                godpg_pkg::ST_ROT:
                begin
                    unique case (k_reg)
                        3'd1:
                        begin
                            rot_a_reg <= sdif;
                            rot_b_reg <= ssum;
                        end
                        3'd2:
                        begin
                            a_reg <= sat_f(-sb);
                            b_reg <= a_reg;
                        end
                        3'd3:
                        begin
                            rot_a_reg <= -ssum;
                            rot_b_reg <= sdif;
                        end
                        3'd4:
                        begin
                            a_reg <= sat_f(-sa);
                            b_reg <= sat_f(-sb);
                        end
                        3'd5:
                        begin
                            rot_a_reg <= -sdif;
                            rot_b_reg <= -ssum;
                        end
                        3'd6:
                        begin
                            a_reg <= b_reg;
                            b_reg <= sat_f(-sa);
                        end
                        3'd7:
                        begin
                            rot_a_reg <= ssum;
                            rot_b_reg <= -sdif;
                        end
                        default: ;
                    endcase
                end
                godpg_pkg::ST_ROUND:
                begin
                    if (k_reg[0])
                    begin
                        a_reg <= sat_f(rot_a);
                        b_reg <= sat_f(rot_b);
                    end
                end
                godpg_pkg::ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_index <= gc_reg;
                        out_real    <= a_reg;
                        out_imag    <= b_reg;
                        final_amp   <= last_reg;
                        if (last_reg)
                        begin
                            count_reg <= '0;
                            prev_reg  <= '0;
                            sign_reg  <= 1'b0;
                        end
                        else
                        begin
                            count_reg <= (count_reg & vec_mask) + 20'd1;
                            prev_reg  <= gc_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    // No beat is taken while the mask memories are being cleared.
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !accept_in) else $error("beat accepted during clear");
    // A result is only produced from the output state.
    a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == godpg_pkg::ST_OUT)
        else $error("stray result");
    // The index after a final beat starts the vector again.
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && final_amp && $rose(out_valid)) |-> (count_reg == '0 && !sign_reg))
        else $error("stream state not cleared");
`endif
endmodule
`default_nettype wire
